FILE: design/gme_pkg.sv
package gme_pkg;

  // wide accumulator for I*W, the sum of Out_c*In_c and W*W
  localparam int AW      = 136;
  // numerator of the final division: difference shifted by 31 plus W*W
  localparam int NUMW    = AW + 32;
  // divisor and partial remainder width
  localparam int DW      = AW + 1;
  localparam int QW      = 32;
  localparam int HALF    = 32;
  localparam int OP_W    = 2 * HALF;
  localparam int LBL_W   = 6;
  localparam int NUM_LBL = 64;
  localparam int ID_W    = 7;
  localparam int WGT_W   = 16;
  localparam int STR_W   = 32;
  localparam int TD_W    = 40;

  typedef enum logic [1:0] {
    FN_CLEAR   = 2'd0,
    FN_EDGE    = 2'd1,
    FN_LABEL   = 2'd2,
    FN_COMPUTE = 2'd3
  } func_t;

  localparam logic CFG_DIRECTED  = 1'b0;
  localparam logic CFG_ONE_BASED = 1'b1;

  typedef enum logic [1:0] {
    MD_POS = 2'd0,
    MD_NEG = 2'd1,
    MD_DEN = 2'd2
  } mul_dst_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic          done;
    logic          ovf;
    logic [QW-1:0] q;
  } gme_div_res_t;

endpackage

FILE: design/gme_divider.sv
module gme_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [gme_pkg::NUMW-1:0] num,
  input  logic [gme_pkg::DW-1:0]   den,
  output gme_pkg::gme_div_res_t  res
);
  import gme_pkg::*;

  localparam int CW = $clog2(NUMW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [NUMW-1:0] num_r;
  logic [DW-1:0]   den_r;
  logic [DW-1:0]   rem_r;
  logic [QW-1:0]   q_r;
  logic            ovf_r;
  logic [DW-1:0]   trial;
  logic            ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r[DW-2:0], num_r[NUMW-1]};
  assign ge    = (trial >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUMW);
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
      end else if (busy_r) begin
        num_r <= {num_r[NUMW-2:0], 1'b0};
        rem_r <= ge ? (trial - den_r) : trial;
        q_r   <= {q_r[QW-2:0], ge};
        // any quotient bit above the low word means saturation
        ovf_r <= ovf_r | q_r[QW-1];
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.q    = q_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> den_r != '0) else $error("divide by zero");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r)) else $error("done without run");

endmodule

FILE: design/graph_modularity_engine.sv
// graph modularity engine
// in_* stream: one transaction per command (clear, add edge, set label,
// compute). out_* stream: one transaction per compute, carrying Q with 30
// fraction bits and a status bit (1 when the total weight is zero).
// cfg_*: write enable, register index (0 directed, 1 one_based), data;
// to be written only while the block is idle; the block does not enforce this.
// set label leaves in_tready high. add edge does a read-modify-write of
// one adjacency word and two strength words per direction, once when
// directed and for both directions when undirected. clear writes one
// adjacency word per cycle. compute does a walk of the adjacency store,
// 66 multiplies through one shared 32x32 multiplier (4 partial products
// each), and a bit-serial divide.
// reset starts the same clearing pass (labels included) with in_tready low.
// a finished result sits in the output register; a new command is taken
// while it waits, and a later compute holds in its last state until the
// receiver has taken the earlier result.
module graph_modularity_engine #(
  parameter int MAX_NODES = 64,
  parameter int ACC_BITS  = 40
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // func[1:0], src_node[8:2], dst_node[15:9], edge_weight[31:16],
  // community_label[37:32], zero pad
  input  logic [gme_pkg::TD_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // modularity[31:0], status[32], zero pad
  output logic [gme_pkg::TD_W-1:0]  out_tdata,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic                      cfg_wdata
);
  import gme_pkg::*;

  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int AWD = 2 * NW;
  localparam int LW  = $clog2(NUM_LBL);
  localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_E_RD, S_E_WR, S_CZ, S_CRD0, S_CRD1, S_CWR,
    S_WALK, S_WTAIL, S_MI, S_SRD, S_SLD, S_SNX, S_MW, S_MUL,
    S_DIFF, S_DIV, S_OUT
  } state_t;

  state_t state_r, ret_r;

  // configuration
  logic directed_r, one_based_r;

  // input fields
  logic [1:0]       f_func;
  logic [ID_W-1:0]  f_src, f_dst;
  logic [WGT_W-1:0] f_w;
  logic [LBL_W-1:0] f_lbl;
  assign f_func = in_tdata[1:0];
  assign f_src  = in_tdata[8:2];
  assign f_dst  = in_tdata[15:9];
  assign f_w    = in_tdata[31:16];
  assign f_lbl  = in_tdata[37:32];

  // node id adjustment and range check
  logic [10:0] s_adj, d_adj;
  logic        s_ok, d_ok;
  assign s_adj = {4'b0, f_src} - {10'b0, one_based_r};
  assign d_adj = {4'b0, f_dst} - {10'b0, one_based_r};
  assign s_ok  = !(one_based_r && f_src == '0) && (s_adj < 11'(MAX_NODES));
  assign d_ok  = !(one_based_r && f_dst == '0) && (d_adj < 11'(MAX_NODES));

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // sequencer registers
  logic [AWD-1:0]      cnt_r;
  logic                clr_lab_r;
  logic [NW-1:0]       s_r, d_r, node_r;
  logic [WGT_W-1:0]    w_r;
  logic                pass_r;
  logic [LW-1:0]       c_r;
  logic [ACC_BITS-1:0] total_r, internal_r;
  logic                walk_v_r;
  logic [OP_W-1:0]     mop_a_r, mop_b_r;
  mul_dst_t            md_r;
  logic [2:0]          mstep_r;
  logic [2*HALF-1:0]   prod_r;
  logic [1:0]          psh_r;
  logic [AW-1:0]       pos_r, neg_r, den_r;
  logic                negq_r;
  logic                out_tvalid_r;
  logic [QW-1:0]       res_q_r;
  logic                res_st_r;

  // memories
  logic [STR_W-1:0]    adj_mem [2**AWD];
  logic [STR_W-1:0]    out_mem [2**NW];
  logic [STR_W-1:0]    in_mem  [2**NW];
  logic [LBL_W-1:0]    lab_mem [2**NW];
  logic [ACC_BITS-1:0] cout_mem [NUM_LBL];
  logic [ACC_BITS-1:0] cin_mem  [NUM_LBL];

  logic [STR_W-1:0]    adj_rd_r, out_rd_r, in_rd_r;
  logic [LBL_W-1:0]    lab_a_rd_r, lab_b_rd_r;
  logic [ACC_BITS-1:0] cout_rd_r, cin_rd_r;

  function automatic logic [STR_W-1:0] sat32(input logic [STR_W-1:0] a,
                                             input logic [WGT_W-1:0] b);
    logic [STR_W:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[STR_W] ? '1 : s[STR_W-1:0];
  endfunction

  function automatic logic [ACC_BITS-1:0] accadd(input logic [ACC_BITS-1:0] a,
                                                 input logic [ACC_BITS-1:0] b);
    logic [ACC_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_BITS] ? ACC_MAX : s[ACC_BITS-1:0];
  endfunction

  // memory port selection
  logic            e_st, clr_st;
  logic [AWD-1:0]  adj_ra, adj_wa;
  logic            adj_we;
  logic [STR_W-1:0] adj_wd;
  logic [NW-1:0]   out_ra, in_ra, out_wa, in_wa, lab_ra, lab_rb, lab_wa;
  logic            str_we, lab_we;
  logic [STR_W-1:0] out_wd, in_wd;
  logic [LBL_W-1:0] lab_wd;
  logic [LW-1:0]   com_ra, com_wa;
  logic            com_we;
  logic [ACC_BITS-1:0] cout_wd, cin_wd;

  assign e_st   = (state_r == S_E_RD) || (state_r == S_E_WR);
  assign clr_st = (state_r == S_CLR);

  assign adj_ra = e_st ? {s_r, d_r} : cnt_r;
  assign adj_we = clr_st || (state_r == S_E_WR);
  assign adj_wa = clr_st ? cnt_r : {s_r, d_r};
  assign adj_wd = clr_st ? '0 : sat32(adj_rd_r, w_r);

  assign out_ra = e_st ? s_r : node_r;
  assign in_ra  = e_st ? d_r : node_r;
  assign str_we = adj_we;
  assign out_wa = clr_st ? cnt_r[NW-1:0] : s_r;
  assign in_wa  = clr_st ? cnt_r[NW-1:0] : d_r;
  assign out_wd = clr_st ? '0 : sat32(out_rd_r, w_r);
  assign in_wd  = clr_st ? '0 : sat32(in_rd_r, w_r);

  assign lab_ra = (state_r == S_WALK) ? cnt_r[AWD-1:NW] : node_r;
  assign lab_rb = cnt_r[NW-1:0];
  assign lab_we = (clr_st && clr_lab_r) ||
                  (in_acc && f_func == FN_LABEL && s_ok);
  assign lab_wa = clr_st ? cnt_r[NW-1:0] : s_adj[NW-1:0];
  assign lab_wd = clr_st ? '0 : f_lbl;

  assign com_ra  = ((state_r == S_SRD) || (state_r == S_SLD)) ? c_r
                                                              : lab_a_rd_r[LW-1:0];
  assign com_we  = (state_r == S_CZ) || (state_r == S_CWR);
  assign com_wa  = (state_r == S_CZ) ? c_r : lab_a_rd_r[LW-1:0];
  assign cout_wd = (state_r == S_CZ) ? '0 : accadd(cout_rd_r, ACC_BITS'(out_rd_r));
  assign cin_wd  = (state_r == S_CZ) ? '0 : accadd(cin_rd_r, ACC_BITS'(in_rd_r));

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_rd_r <= adj_mem[adj_ra];
  end

  always_ff @(posedge clk) begin
    if (str_we) begin
      out_mem[out_wa] <= out_wd;
      in_mem[in_wa]   <= in_wd;
    end
    out_rd_r <= out_mem[out_ra];
    in_rd_r  <= in_mem[in_ra];
  end

  always_ff @(posedge clk) begin
    if (lab_we) lab_mem[lab_wa] <= lab_wd;
    lab_a_rd_r <= lab_mem[lab_ra];
    lab_b_rd_r <= lab_mem[lab_rb];
  end

  always_ff @(posedge clk) begin
    if (com_we) begin
      cout_mem[com_wa] <= cout_wd;
      cin_mem[com_wa]  <= cin_wd;
    end
    cout_rd_r <= cout_mem[com_ra];
    cin_rd_r  <= cin_mem[com_ra];
  end

  // shared multiplier: partial product of the selected halves
  logic [HALF-1:0] m_ah, m_bh;
  logic [AW-1:0]   m_term;
  assign m_ah   = mstep_r[1] ? mop_a_r[OP_W-1:HALF] : mop_a_r[HALF-1:0];
  assign m_bh   = mstep_r[0] ? mop_b_r[OP_W-1:HALF] : mop_b_r[HALF-1:0];
  assign m_term = AW'(prod_r) << {psh_r, 5'b0};

  // signed difference and divider operands
  logic            diff_neg;
  logic [AW-1:0]   diff;
  logic [NUMW-1:0] div_num;
  logic [DW-1:0]   div_den;
  logic            div_start;
  gme_div_res_t    div_res;
  assign diff_neg  = pos_r < neg_r;
  assign diff      = diff_neg ? (neg_r - pos_r) : (pos_r - neg_r);
  assign div_num   = (NUMW'(diff) << 31) + NUMW'(den_r);
  assign div_den   = {den_r, 1'b0};
  assign div_start = (state_r == S_DIFF);

  gme_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  // final rounding already folded in; saturate to 32 bits
  logic [QW-1:0] q_sat;
  always_comb begin
    if (negq_r) begin
      q_sat = (div_res.ovf || div_res.q > 32'h8000_0000) ? 32'h8000_0000
                                                         : (32'd0 - div_res.q);
    end else begin
      q_sat = (div_res.ovf || div_res.q[QW-1]) ? 32'h7FFF_FFFF : div_res.q;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      ret_r        <= S_IDLE;
      cnt_r        <= '0;
      clr_lab_r    <= 1'b1;
      directed_r   <= 1'b0;
      one_based_r  <= 1'b0;
      total_r      <= '0;
      walk_v_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
      mstep_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_DIRECTED:  directed_r  <= cfg_wdata;
          CFG_ONE_BASED: one_based_r <= cfg_wdata;
          default: ;
        endcase
      end
      // the output state reloads the result register itself
      if (out_tready && state_r != S_OUT) out_tvalid_r <= 1'b0;

      // internal weight accumulation follows the walk read in the next cycle
      walk_v_r <= (state_r == S_WALK);
      if (walk_v_r && lab_a_rd_r == lab_b_rd_r)
        internal_r <= accadd(internal_r, ACC_BITS'(adj_rd_r));

      case (state_r)
        S_CLR: begin
          total_r <= '0;
          cnt_r   <= cnt_r + AWD'(1);
          if (cnt_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            case (func_t'(f_func))
              FN_CLEAR: begin
                cnt_r     <= '0;
                clr_lab_r <= 1'b0;
                state_r   <= S_CLR;
              end
              FN_EDGE: begin
                s_r    <= s_adj[NW-1:0];
                d_r    <= d_adj[NW-1:0];
                w_r    <= f_w;
                pass_r <= 1'b0;
                if (s_ok && d_ok) state_r <= S_E_RD;
              end
              FN_COMPUTE: begin
                internal_r <= '0;
                pos_r      <= '0;
                neg_r      <= '0;
                den_r      <= '0;
                c_r        <= '0;
                node_r     <= '0;
                if (total_r == '0) begin
                  res_q_r  <= '0;
                  res_st_r <= 1'b1;
                  state_r  <= S_OUT;
                end else begin
                  state_r <= S_CZ;
                end
              end
              default: ;
            endcase
          end
        end
        S_E_RD: state_r <= S_E_WR;
        S_E_WR: begin
          total_r <= accadd(total_r, ACC_BITS'(w_r));
          if (!directed_r && !pass_r) begin
            s_r     <= d_r;
            d_r     <= s_r;
            pass_r  <= 1'b1;
            state_r <= S_E_RD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        // community sums rebuilt from zero
        S_CZ: begin
          c_r <= c_r + LW'(1);
          if (c_r == '1) state_r <= S_CRD0;
        end
        S_CRD0: state_r <= S_CRD1;
        S_CRD1: state_r <= S_CWR;
        S_CWR: begin
          node_r <= node_r + NW'(1);
          if (node_r == '1) begin
            cnt_r   <= '0;
            state_r <= S_WALK;
          end else begin
            state_r <= S_CRD0;
          end
        end
        S_WALK: begin
          cnt_r <= cnt_r + AWD'(1);
          if (cnt_r == '1) state_r <= S_WTAIL;
        end
        S_WTAIL: state_r <= S_MI;
        S_MI: begin
          mop_a_r <= OP_W'(internal_r);
          mop_b_r <= OP_W'(total_r);
          md_r    <= MD_POS;
          ret_r   <= S_SRD;
          c_r     <= '0;
          mstep_r <= '0;
          state_r <= S_MUL;
        end
        S_SRD: state_r <= S_SLD;
        S_SLD: begin
          mop_a_r <= OP_W'(cout_rd_r);
          mop_b_r <= OP_W'(cin_rd_r);
          md_r    <= MD_NEG;
          ret_r   <= S_SNX;
          mstep_r <= '0;
          state_r <= S_MUL;
        end
        S_SNX: begin
          c_r <= c_r + LW'(1);
          state_r <= (c_r == '1) ? S_MW : S_SRD;
        end
        S_MW: begin
          mop_a_r <= OP_W'(total_r);
          mop_b_r <= OP_W'(total_r);
          md_r    <= MD_DEN;
          ret_r   <= S_DIFF;
          mstep_r <= '0;
          state_r <= S_MUL;
        end
        // four partial products, each registered and added in the following cycle
        S_MUL: begin
          if (mstep_r < 3'd4) begin
            prod_r <= m_ah * m_bh;
            psh_r  <= {1'b0, mstep_r[1]} + {1'b0, mstep_r[0]};
          end
          if (mstep_r != 3'd0) begin
            case (md_r)
              MD_POS:  pos_r <= pos_r + m_term;
              MD_NEG:  neg_r <= neg_r + m_term;
              MD_DEN:  den_r <= den_r + m_term;
              default: ;
            endcase
          end
          mstep_r <= mstep_r + 3'd1;
          if (mstep_r == 3'd4) state_r <= ret_r;
        end
        S_DIFF: begin
          negq_r  <= diff_neg;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_res.done) begin
            res_q_r  <= q_sat;
            res_st_r <= 1'b0;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata    <= {7'b0, res_st_r, res_q_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside output state");
  a_diff_nonzero_w: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIFF |-> total_r != '0 && den_r != '0)
    else $error("division entered with zero weight");
  a_mul_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> mstep_r <= 3'd4)
    else $error("multiplier step out of range");

endmodule
